// ===== hdl/gha_pkg.sv =====
// shared types and constants of the generational handle allocator
// no dependencies
`default_nettype none
package gha_pkg;

    localparam int SLOTS       = 256;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int QUEUE_DEPTH = 16;
    localparam int QI_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 9;
    localparam int VER_W       = 16;
    localparam int CNT_W       = 9;

    typedef enum logic [1:0] {
        CMD_CREATE  = 2'd0,
        CMD_DESTROY = 2'd1,
        CMD_CHECK   = 2'd2,
        CMD_COMMIT  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        RK_CREATE    = 3'd0,
        RK_DESTROY   = 3'd1,
        RK_CHECK     = 3'd2,
        RK_CREATED   = 3'd3,
        RK_DESTROYED = 3'd4,
        RK_DONE      = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_QFULL   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CREATE,
        S_HANDLE,
        S_CM_RD,
        S_CM_EX
    } t_state;

    typedef struct packed {
        t_cmd              cmd;
        logic              id_zero;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
        logic [VER_W-1:0]  ver;
    } t_front_word;

    // slot table entry, written when a slot is opened, destroyed, committed or retired
    typedef struct packed {
        logic             active;
        logic             doomed;
        logic [VER_W-1:0] ver;
    } t_slot_entry;

endpackage
`default_nettype wire

// ===== hdl/gha_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== hdl/gha_front.sv =====
// front end: accepts input words, classifies them, two entry queue to the back end
// depends on gha_pkg
`default_nettype none
module gha_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [1:0]                 i_command,
    input  wire logic [gha_pkg::ID_W-1:0]   i_handle_id,
    input  wire logic [gha_pkg::VER_W-1:0]  i_handle_version,
    output logic                            o_valid,
    output gha_pkg::t_front_word            o_word,
    input  wire logic                       i_pop
);
    import gha_pkg::*;

    t_front_word r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push;
    t_front_word cls;
    logic [ID_W-1:0] id_m1;

    assign o_in_stall = (r_cnt == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_valid    = (r_cnt != 2'd0);
    assign o_word     = r_mem[r_rp];

    always_comb begin
        id_m1       = i_handle_id - ID_W'(1);
        cls.cmd     = t_cmd'(i_command);
        cls.id_zero = (i_handle_id == '0);
        cls.slot    = id_m1[SLOT_W-1:0];
        cls.id      = i_handle_id;
        cls.ver     = i_handle_version;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= cls;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end
endmodule
`default_nettype wire

// ===== hdl/gha_back.sv =====
// back end: slot table, free list, pending queue, commit walk and result register
// depends on gha_pkg and gha_ram
`default_nettype none
module gha_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire gha_pkg::t_front_word       i_word,
    output logic                            o_pop,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [2:0]                      o_result_kind,
    output logic [gha_pkg::ID_W-1:0]        o_out_id,
    output logic [gha_pkg::VER_W-1:0]       o_out_version,
    output logic [1:0]                      o_status,
    output logic [gha_pkg::CNT_W-1:0]       o_live_count,
    output logic                            o_last
);
    import gha_pkg::*;

    t_state r_state, n_state;
    logic [SLOT_W:0]  r_opened, n_opened;
    logic [SLOT_W-1:0] r_head, n_head, r_tail, n_tail;
    logic r_empty, n_empty;
    logic [QCNT_W-1:0] r_pcnt, n_pcnt, r_idx, n_idx;
    logic [CNT_W-1:0]  r_total, n_total;
    logic              r_qd  [QUEUE_DEPTH];
    logic [SLOT_W-1:0] r_qs  [QUEUE_DEPTH];
    logic [VER_W-1:0]  r_qv  [QUEUE_DEPTH];
    logic              q_we, q_wd;
    logic [SLOT_W-1:0] q_ws;
    logic [VER_W-1:0]  q_wv;

    logic [SLOT_W-1:0] r_slot, n_slot;
    t_cmd              r_cmd, n_cmd;
    logic [ID_W-1:0]   r_id, n_id;
    logic [VER_W-1:0]  r_ver, n_ver;
    logic              r_pre, n_pre;

    logic r_ov, n_ov;
    logic [2:0] r_ok, n_ok;
    logic [ID_W-1:0] r_oid, n_oid;
    logic [VER_W-1:0] r_over, n_over;
    logic [1:0] r_ost, n_ost;
    logic [CNT_W-1:0] r_olive, n_olive;
    logic r_olast, n_olast;

    logic              v_we, nf_we;
    logic [SLOT_W-1:0] v_waddr, nf_waddr, v_raddr, nf_raddr;
    t_slot_entry       v_wdata, v_rdata;
    logic [SLOT_W-1:0] nf_wdata, nf_rdata;
    logic              out_free, qfull, live;

    gha_ram #(.WIDTH($bits(t_slot_entry)), .DEPTH(SLOTS)) u_ver (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );
    gha_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_next (
        .i_clk(i_clk), .i_we(nf_we), .i_waddr(nf_waddr), .i_wdata(nf_wdata),
        .i_raddr(nf_raddr), .o_rdata(nf_rdata)
    );

    assign out_free = !r_ov || !i_out_stall;
    assign qfull    = (32'(r_pcnt) >= QUEUE_DEPTH);
    assign live     = r_pre && v_rdata.active && !v_rdata.doomed && (v_rdata.ver == r_ver);

    always_comb begin
        n_state = r_state;
        n_opened = r_opened; n_head = r_head; n_tail = r_tail; n_empty = r_empty;
        n_pcnt = r_pcnt; n_idx = r_idx; n_total = r_total;
        n_slot = r_slot; n_cmd = r_cmd; n_id = r_id; n_ver = r_ver; n_pre = r_pre;
        n_ov = r_ov && i_out_stall;
        n_ok = r_ok; n_oid = r_oid; n_over = r_over; n_ost = r_ost;
        n_olive = r_olive; n_olast = r_olast;
        q_we = 1'b0; q_wd = 1'b0; q_ws = r_slot; q_wv = v_rdata.ver;
        v_we = 1'b0; v_waddr = r_slot; v_wdata = '0;
        nf_we = 1'b0; nf_waddr = r_tail; nf_wdata = r_slot;
        v_raddr = r_slot; nf_raddr = r_slot;
        o_pop = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                v_raddr  = (i_word.cmd == CMD_CREATE) ? r_head : i_word.slot;
                nf_raddr = r_head;
                if (i_valid && out_free) begin
                    o_pop = 1'b1;
                    n_cmd = i_word.cmd;
                    n_id  = i_word.id;
                    n_ver = i_word.ver;
                    unique case (i_word.cmd)
                        CMD_CREATE: begin
                            if (qfull || (r_empty && 32'(r_opened) >= SLOTS)) begin
                                n_ov = 1'b1; n_ok = RK_CREATE; n_oid = '0; n_over = '0;
                                n_ost = qfull ? ST_QFULL : ST_FULL;
                                n_olive = r_total; n_olast = 1'b1;
                            end else if (r_empty) begin
                                v_we = 1'b1; v_waddr = r_opened[SLOT_W-1:0]; v_wdata = '0;
                                n_opened = r_opened + 1'b1;
                                q_we = 1'b1; q_wd = 1'b0;
                                q_ws = r_opened[SLOT_W-1:0]; q_wv = '0;
                                n_pcnt = r_pcnt + 1'b1;
                                n_ov = 1'b1; n_ok = RK_CREATE;
                                n_oid = ID_W'(r_opened) + ID_W'(1); n_over = '0;
                                n_ost = ST_OK; n_olive = r_total; n_olast = 1'b1;
                            end else begin
                                n_slot  = r_head;
                                n_state = S_CREATE;
                            end
                        end
                        CMD_DESTROY, CMD_CHECK: begin
                            n_slot  = i_word.slot;
                            n_pre   = !i_word.id_zero
                                    && (32'(i_word.id) <= 32'(r_opened));
                            n_state = S_HANDLE;
                        end
                        default: begin
                            n_idx   = '0;
                            n_state = S_CM_RD;
                        end
                    endcase
                end
            end
            S_CREATE: begin
                if (out_free) begin
                    if (r_head == r_tail) n_empty = 1'b1;
                    else n_head = nf_rdata;
                    q_we = 1'b1; q_wd = 1'b0; q_ws = r_slot; q_wv = v_rdata.ver;
                    n_pcnt = r_pcnt + 1'b1;
                    n_ov = 1'b1; n_ok = RK_CREATE;
                    n_oid = ID_W'(r_slot) + ID_W'(1); n_over = v_rdata.ver;
                    n_ost = ST_OK; n_olive = r_total; n_olast = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_HANDLE: begin
                if (out_free) begin
                    n_ov = 1'b1; n_oid = r_id; n_over = r_ver;
                    n_olive = r_total; n_olast = 1'b1;
                    if (r_cmd == CMD_CHECK) begin
                        n_ok  = RK_CHECK;
                        n_ost = live ? ST_OK : ST_INVALID;
                    end else begin
                        n_ok = RK_DESTROY;
                        if (!live) begin
                            n_ost = ST_INVALID;
                        end else if (qfull) begin
                            n_ost = ST_QFULL;
                        end else begin
                            n_ost = ST_OK;
                            v_we = 1'b1; v_waddr = r_slot;
                            v_wdata = v_rdata; v_wdata.doomed = 1'b1;
                            q_we = 1'b1; q_wd = 1'b1; q_ws = r_slot; q_wv = v_rdata.ver;
                            n_pcnt = r_pcnt + 1'b1;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            S_CM_RD: begin
                v_raddr = r_qs[r_idx[QI_W-1:0]];
                if (r_idx == r_pcnt) begin
                    if (out_free) begin
                        n_ov = 1'b1; n_ok = RK_DONE; n_oid = '0; n_over = '0;
                        n_ost = ST_OK; n_olive = r_total; n_olast = 1'b1;
                        n_pcnt = '0;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_slot  = r_qs[r_idx[QI_W-1:0]];
                    n_state = S_CM_EX;
                end
            end
            S_CM_EX: begin
                if (!r_qd[r_idx[QI_W-1:0]]) begin
                    if (out_free) begin
                        v_we = 1'b1; v_waddr = r_slot;
                        v_wdata = v_rdata; v_wdata.active = 1'b1;
                        n_total = r_total + 1'b1;
                        n_ov = 1'b1; n_ok = RK_CREATED;
                        n_oid = ID_W'(r_slot) + ID_W'(1); n_over = v_rdata.ver;
                        n_ost = ST_OK; n_olive = n_total; n_olast = 1'b0;
                        n_idx = r_idx + 1'b1;
                        n_state = S_CM_RD;
                    end
                end else if (v_rdata.ver != r_qv[r_idx[QI_W-1:0]]) begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_CM_RD;
                end else if (out_free) begin
                    if (r_total != '0) n_total = r_total - 1'b1;
                    n_ov = 1'b1; n_ok = RK_DESTROYED;
                    n_oid = ID_W'(r_slot) + ID_W'(1); n_over = v_rdata.ver;
                    n_ost = ST_OK; n_olive = n_total; n_olast = 1'b0;
                    v_we = 1'b1; v_waddr = r_slot;
                    v_wdata.active = 1'b0; v_wdata.doomed = 1'b0;
                    v_wdata.ver = v_rdata.ver + 1'b1;
                    if (r_empty) begin
                        n_head = r_slot; n_tail = r_slot; n_empty = 1'b0;
                    end else begin
                        nf_we = 1'b1; nf_waddr = r_tail; nf_wdata = r_slot;
                        n_tail = r_slot;
                    end
                    n_idx = r_idx + 1'b1;
                    n_state = S_CM_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_qd[r_pcnt[QI_W-1:0]] <= q_wd;
            r_qs[r_pcnt[QI_W-1:0]] <= q_ws;
            r_qv[r_pcnt[QI_W-1:0]] <= q_wv;
        end
        r_slot <= n_slot; r_cmd <= n_cmd; r_id <= n_id; r_ver <= n_ver; r_pre <= n_pre;
        r_ok <= n_ok; r_oid <= n_oid; r_over <= n_over; r_ost <= n_ost;
        r_olive <= n_olive; r_olast <= n_olast;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_opened <= '0; r_empty <= 1'b1;
            r_pcnt <= '0; r_idx <= '0; r_total <= '0;
            r_ov <= 1'b0;
            r_head <= '0; r_tail <= '0;
        end else begin
            r_state <= n_state;
            r_opened <= n_opened; r_empty <= n_empty;
            r_pcnt <= n_pcnt; r_idx <= n_idx; r_total <= n_total;
            r_ov <= n_ov;
            r_head <= n_head; r_tail <= n_tail;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_result_kind = r_ok;
    assign o_out_id      = r_oid;
    assign o_out_version = r_over;
    assign o_status      = r_ost;
    assign o_live_count  = r_olive;
    assign o_last        = r_olast;
endmodule
`default_nettype wire

// ===== hdl/generational_handle_allocator_unit.sv =====
// top level of the generational handle allocator: front queue plus back end
// depends on gha_pkg, gha_front, gha_back
// create of a fresh slot is done in the dispatch state; create from the free list,
// destroy and check add S_CREATE or S_HANDLE, due to the registered slot table read
// commit: dispatch, then S_CM_RD and S_CM_EX per queued command, then the done word
// results leave through a one word output register; a stalled output holds the back end
// synchronous active low reset clears all control state, no clearing pass
`default_nettype none
module generational_handle_allocator_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [1:0]                i_command,
    input  wire logic [gha_pkg::ID_W-1:0]  i_handle_id,
    input  wire logic [gha_pkg::VER_W-1:0] i_handle_version,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic [2:0]                     o_result_kind,
    output logic [gha_pkg::ID_W-1:0]       o_out_id,
    output logic [gha_pkg::VER_W-1:0]      o_out_version,
    output logic [1:0]                     o_status,
    output logic [gha_pkg::CNT_W-1:0]      o_live_count,
    output logic                           o_last
);
    import gha_pkg::*;

    logic        f_valid, f_pop;
    t_front_word f_word;

    gha_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_command(i_command), .i_handle_id(i_handle_id),
        .i_handle_version(i_handle_version),
        .o_valid(f_valid), .o_word(f_word), .i_pop(f_pop)
    );

    gha_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .i_word(f_word), .o_pop(f_pop),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_result_kind(o_result_kind), .o_out_id(o_out_id),
        .o_out_version(o_out_version), .o_status(o_status),
        .o_live_count(o_live_count), .o_last(o_last)
    );
endmodule
`default_nettype wire
